FILE: hw/rtl/nearest_neighbor_frame_scaler_assert.svh
// Assertion macros used by the frame scaler top level.
// Expects clk and arst_n in the scope where a macro is used.
`ifndef NEAREST_NEIGHBOR_FRAME_SCALER_ASSERT_SVH
`define NEAREST_NEIGHBOR_FRAME_SCALER_ASSERT_SVH

// cond must hold at every clock edge out of reset
`define NNFS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// cons must hold in the same cycle as ante
`define NNFS_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// cons must hold in the cycle after ante
`define NNFS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hw/rtl/nnfs_pkg.sv
// Package for the nearest-neighbor frame scaler: widths, register map, pipeline depth
// and the per-axis configuration bundle. No dependencies.
package nnfs_pkg;

	localparam int BYTES_PER_PIXEL = 2;
	localparam int MAX_DIM         = 4096;

	localparam int COORD_W = $clog2(MAX_DIM);
	localparam int CFG_W   = COORD_W + 1;
	localparam int ADDR_W  = 26;
	localparam int NUM_W   = 2 * CFG_W;

	// Divider retires one quotient bit per stage
	localparam int DIV_STEPS   = CFG_W;
	localparam int AXIS_STAGES = 2 + DIV_STEPS;
	localparam int NSTAGE      = AXIS_STAGES + 1;

	localparam bit ALPHA_EN = BYTES_PER_PIXEL > 2;

	localparam int IN_FIELDS_W  = 2 * COORD_W;
	localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_FIELDS_W = 2 * COORD_W + ADDR_W;
	localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;
	localparam int OUT_USER_W   = 2;

	localparam int PDATA_W = 32;
	localparam int REG_W   = 3;
	localparam int PADDR_W = REG_W + 2;

	typedef enum logic [REG_W-1:0] {
		REG_SRC_WIDTH      = 3'd0,
		REG_SRC_HEIGHT     = 3'd1,
		REG_CONTENT_WIDTH  = 3'd2,
		REG_CONTENT_HEIGHT = 3'd3,
		REG_X_OFFSET       = 3'd4,
		REG_Y_OFFSET       = 3'd5,
		REG_BUFFER_WIDTH   = 3'd6,
		REG_BUFFER_HEIGHT  = 3'd7
	} reg_idx_t;

	// Settings for one axis, to be held static by the user while items are in flight (not enforced)
	typedef struct packed {
		logic [CFG_W-1:0]        src;
		logic [CFG_W-1:0]        content;
		logic signed [CFG_W-1:0] offset;
		logic [CFG_W-1:0]        buf_dim;
	} axis_cfg_t;

endpackage

FILE: hw/rtl/nearest_neighbor_frame_scaler.sv
// Nearest-neighbor frame scaler, address side: top level with registers and pipeline control.
// Depends on nnfs_pkg, nnfs_axis_map and nearest_neighbor_frame_scaler_assert.svh.
//
// Usage:
//   Input stream s_*: one destination pixel per transfer, s_tdata = {dst_row, dst_col}.
//   Output stream m_*: one result per input, same order. m_tdata holds src_col,
//   src_row and dst_byte_addr; m_tuser holds inside_res and write_alpha.
//   Pixels outside the clipped content window come out with every field zero.
//   User must write registers over the APB port only while no transfer is in flight (not enforced).
//   The pipeline runs from input transfer to output transfer through one input stage, one
//   multiply stage, 13 divider stages (one quotient bit each) and one output stage.
//   Throughput is one pixel per clock while m_tready is high; the 13-stage restoring
//   divider per axis sets the depth.
//   Each stage loads whenever it is empty or the stage after it moves, so bubbles
//   close up and input keeps flowing while a result waits, until all 16 stages
//   are full. A stall never drops or repeats a pixel.
//   Reset empties the pipeline and returns the registers to 1x1 source, content
//   and buffer with zero offsets.
`include "nearest_neighbor_frame_scaler_assert.svh"

module nearest_neighbor_frame_scaler (
	input  logic                                  clk,
	input  logic                                  arst_n,
	// APB configuration
	input  logic                                  psel,
	input  logic                                  penable,
	input  logic                                  pwrite,
	input  logic [nnfs_pkg::PADDR_W-1:0]          paddr,
	input  logic [nnfs_pkg::PDATA_W-1:0]          pwdata,
	output logic [nnfs_pkg::PDATA_W-1:0]          prdata,
	output logic                                  pready,
	// pixel coordinates in
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	input  logic [nnfs_pkg::IN_DATA_W-1:0]        s_tdata,  // dst_col, dst_row
	// mapped results out
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [nnfs_pkg::OUT_DATA_W-1:0]       m_tdata,  // src_col, src_row, dst_byte_addr, pad
	output logic [nnfs_pkg::OUT_USER_W-1:0]       m_tuser   // inside_res, write_alpha
);

	localparam int COORD_W  = nnfs_pkg::COORD_W;
	localparam int CFG_W    = nnfs_pkg::CFG_W;
	localparam int ADDR_W   = nnfs_pkg::ADDR_W;
	localparam int NSTAGE   = nnfs_pkg::NSTAGE;
	localparam int STEPS    = nnfs_pkg::DIV_STEPS;
	localparam int PAD_W    = nnfs_pkg::OUT_DATA_W - nnfs_pkg::OUT_FIELDS_W;
	localparam int PADDR_HI = nnfs_pkg::PADDR_W - 1;

	// ---------------- configuration registers ----------------
	logic [CFG_W-1:0]        src_width_q;
	logic [CFG_W-1:0]        src_height_q;
	logic [CFG_W-1:0]        content_width_q;
	logic [CFG_W-1:0]        content_height_q;
	logic signed [CFG_W-1:0] x_offset_q;
	logic signed [CFG_W-1:0] y_offset_q;
	logic [CFG_W-1:0]        buffer_width_q;
	logic [CFG_W-1:0]        buffer_height_q;

	logic                    cfg_wr;
	nnfs_pkg::reg_idx_t      reg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = nnfs_pkg::reg_idx_t'(paddr[PADDR_HI:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			src_width_q      <= CFG_W'(1);
			src_height_q     <= CFG_W'(1);
			content_width_q  <= CFG_W'(1);
			content_height_q <= CFG_W'(1);
			x_offset_q       <= '0;
			y_offset_q       <= '0;
			buffer_width_q   <= CFG_W'(1);
			buffer_height_q  <= CFG_W'(1);
		end else if (cfg_wr) begin
			unique case (reg_idx)
				nnfs_pkg::REG_SRC_WIDTH:      src_width_q      <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_SRC_HEIGHT:     src_height_q     <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_CONTENT_WIDTH:  content_width_q  <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_CONTENT_HEIGHT: content_height_q <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_X_OFFSET:       x_offset_q       <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_Y_OFFSET:       y_offset_q       <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_BUFFER_WIDTH:   buffer_width_q   <= pwdata[CFG_W-1:0];
				nnfs_pkg::REG_BUFFER_HEIGHT:  buffer_height_q  <= pwdata[CFG_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			nnfs_pkg::REG_SRC_WIDTH:      prdata[CFG_W-1:0] = src_width_q;
			nnfs_pkg::REG_SRC_HEIGHT:     prdata[CFG_W-1:0] = src_height_q;
			nnfs_pkg::REG_CONTENT_WIDTH:  prdata[CFG_W-1:0] = content_width_q;
			nnfs_pkg::REG_CONTENT_HEIGHT: prdata[CFG_W-1:0] = content_height_q;
			nnfs_pkg::REG_X_OFFSET:       prdata[CFG_W-1:0] = x_offset_q;
			nnfs_pkg::REG_Y_OFFSET:       prdata[CFG_W-1:0] = y_offset_q;
			nnfs_pkg::REG_BUFFER_WIDTH:   prdata[CFG_W-1:0] = buffer_width_q;
			nnfs_pkg::REG_BUFFER_HEIGHT:  prdata[CFG_W-1:0] = buffer_height_q;
			default: ;
		endcase
	end

	// ---------------- pipeline control ----------------
	logic [NSTAGE-1:0] stage_vld_q;
	logic [NSTAGE:0]   stage_rdy;

	// A stage may load when it is empty or its contents move on this cycle
	always_comb begin
		stage_rdy[NSTAGE] = m_tready;
		for (int k = NSTAGE - 1; k >= 0; k--) begin
			stage_rdy[k] = !stage_vld_q[k] || stage_rdy[k + 1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_vld_q <= '0;
		end else begin
			if (stage_rdy[0]) begin
				stage_vld_q[0] <= s_tvalid;
			end
			for (int k = 1; k < NSTAGE; k++) begin
				if (stage_rdy[k]) begin
					stage_vld_q[k] <= stage_vld_q[k - 1];
				end
			end
		end
	end

	assign s_tready = stage_rdy[0];

	// ---------------- per-axis mapping ----------------
	nnfs_pkg::axis_cfg_t   cfg_x;
	nnfs_pkg::axis_cfg_t   cfg_y;
	logic                  in_x;
	logic                  in_y;
	logic [CFG_W-1:0]      quot_x;
	logic [CFG_W-1:0]      quot_y;

	assign cfg_x = '{src: src_width_q, content: content_width_q,
		offset: x_offset_q, buf_dim: buffer_width_q};
	assign cfg_y = '{src: src_height_q, content: content_height_q,
		offset: y_offset_q, buf_dim: buffer_height_q};

	nnfs_axis_map u_map_x (
		.clk    (clk),
		.en     (stage_rdy[nnfs_pkg::AXIS_STAGES-1:0]),
		.cfg    (cfg_x),
		.d      (s_tdata[COORD_W-1:0]),
		.in_win (in_x),
		.quot   (quot_x)
	);

	nnfs_axis_map u_map_y (
		.clk    (clk),
		.en     (stage_rdy[nnfs_pkg::AXIS_STAGES-1:0]),
		.cfg    (cfg_y),
		.d      (s_tdata[2*COORD_W-1:COORD_W]),
		.in_win (in_y),
		.quot   (quot_y)
	);

	// ---------------- destination address, carried alongside ----------------
	logic [COORD_W-1:0] col_s1;
	logic [COORD_W-1:0] row_s1;
	logic [ADDR_W-1:0]  addr_lin;
	logic [ADDR_W-1:0]  addr_s2;
	// index k rides with divider stage s3+k
	logic [ADDR_W-1:0]  addr_s3 [STEPS];

	always_comb begin
		addr_lin = ADDR_W'(row_s1) * ADDR_W'(buffer_width_q) + ADDR_W'(col_s1);
	end

	always_ff @(posedge clk) begin
		if (stage_rdy[0]) begin
			col_s1 <= s_tdata[COORD_W-1:0];
			row_s1 <= s_tdata[2*COORD_W-1:COORD_W];
		end
		if (stage_rdy[1]) begin
			addr_s2 <= ADDR_W'(addr_lin * ADDR_W'(nnfs_pkg::BYTES_PER_PIXEL));
		end
		if (stage_rdy[2]) begin
			addr_s3[0] <= addr_s2;
		end
		for (int k = 1; k < STEPS; k++) begin
			if (stage_rdy[k + 2]) begin
				addr_s3[k] <= addr_s3[k - 1];
			end
		end
	end

	// ---------------- output stage ----------------
	logic               inside_now;
	logic               res_inside_s16;
	logic               res_alpha_s16;
	logic [COORD_W-1:0] res_col_s16;
	logic [COORD_W-1:0] res_row_s16;
	logic [ADDR_W-1:0]  res_addr_s16;

	assign inside_now = in_x && in_y;

	// Everything reads zero outside the window
	always_ff @(posedge clk) begin
		if (stage_rdy[NSTAGE-1]) begin
			res_inside_s16 <= inside_now;
			res_alpha_s16  <= inside_now && nnfs_pkg::ALPHA_EN;
			res_col_s16    <= inside_now ? quot_x[COORD_W-1:0] : '0;
			res_row_s16    <= inside_now ? quot_y[COORD_W-1:0] : '0;
			res_addr_s16   <= inside_now ? addr_s3[STEPS-1] : '0;
		end
	end

	assign m_tvalid = stage_vld_q[NSTAGE-1];
	assign m_tdata  = {{PAD_W{1'b0}}, res_addr_s16, res_row_s16, res_col_s16};
	assign m_tuser  = {res_alpha_s16, res_inside_s16};

	// ---------------- checks ----------------
	`NNFS_ASSERT_SAME(a_outside_zero, m_tvalid && !m_tuser[0],
		m_tdata == '0 && !m_tuser[1], "outside pixel carries nonzero fields")

	`NNFS_ASSERT_ALWAYS(a_alpha_needs_inside, !m_tvalid || !m_tuser[1] || m_tuser[0],
		"write_alpha set for a pixel outside the window")

	`NNFS_ASSERT_SAME(a_full_stall_blocks, (&stage_vld_q) && !m_tready, !s_tready,
		"input taken while pipeline full and stalled")

	`NNFS_ASSERT_SAME(a_col_in_range,
		m_tvalid && m_tuser[0] && src_width_q <= CFG_W'(nnfs_pkg::MAX_DIM),
		{1'b0, m_tdata[COORD_W-1:0]} < src_width_q, "source column past source width")

	`NNFS_ASSERT_SAME(a_row_in_range,
		m_tvalid && m_tuser[0] && src_height_q <= CFG_W'(nnfs_pkg::MAX_DIM),
		{1'b0, m_tdata[2*COORD_W-1:COORD_W]} < src_height_q,
		"source row past source height")

endmodule

FILE: hw/rtl/nnfs_axis_map.sv
// One axis of the scaler: window clip test and pipelined source index division.
// Depends on nnfs_pkg; stage loads are driven by the top level's handshake chain.
module nnfs_axis_map (
	input  logic                                clk,
	input  logic [nnfs_pkg::AXIS_STAGES-1:0]    en,
	input  nnfs_pkg::axis_cfg_t                 cfg,
	input  logic [nnfs_pkg::COORD_W-1:0]        d,
	output logic                                in_win,
	output logic [nnfs_pkg::CFG_W-1:0]          quot
);

	localparam int CFG_W  = nnfs_pkg::CFG_W;
	localparam int NUM_W  = nnfs_pkg::NUM_W;
	localparam int DIFF_W = CFG_W + 2;
	localparam int STEPS  = nnfs_pkg::DIV_STEPS;

	// Work word is {partial remainder, numerator bits left / quotient bits so far}
	function automatic logic [NUM_W-1:0] div_step(input logic [NUM_W-1:0] w,
			input logic [CFG_W-1:0] dv);
		logic [CFG_W:0] t;
		logic [CFG_W:0] dif;
		t   = {w[NUM_W-1:CFG_W], w[CFG_W-1]};
		dif = t - {1'b0, dv};
		if (t >= {1'b0, dv}) begin
			return {dif[CFG_W-1:0], w[CFG_W-2:0], 1'b1};
		end
		return {t[CFG_W-1:0], w[CFG_W-2:0], 1'b0};
	endfunction

	logic [CFG_W-1:0]        cont_eff;
	logic signed [DIFF_W-1:0] diff;
	logic                    in_now;

	logic [CFG_W-1:0] diff_s1;
	logic             in_s1;
	logic [NUM_W-1:0] num_s2;
	logic             in_s2;
	// index k holds divider stage s3+k
	logic [NUM_W-1:0] work_s3 [STEPS];
	logic             in_s3   [STEPS];

	// Zero content size falls back to the buffer size
	always_comb begin
		cont_eff = (cfg.content != '0) ? cfg.content : cfg.buf_dim;
		diff     = $signed({{(DIFF_W - nnfs_pkg::COORD_W){1'b0}}, d})
			- $signed({{(DIFF_W - CFG_W){cfg.offset[CFG_W-1]}}, cfg.offset});
		// d >= max(0,off) and d < min(buf, off+content) and src != 0
		in_now   = !diff[DIFF_W-1]
			&& (diff[DIFF_W-2:0] < {1'b0, cont_eff})
			&& ({1'b0, d} < cfg.buf_dim)
			&& (cfg.src != '0);
	end

	always_ff @(posedge clk) begin
		if (en[0]) begin
			diff_s1 <= diff[CFG_W-1:0];
			in_s1   <= in_now;
		end
		if (en[1]) begin
			num_s2 <= NUM_W'(diff_s1) * NUM_W'(cfg.src);
			in_s2  <= in_s1;
		end
		if (en[2]) begin
			work_s3[0] <= div_step(num_s2, cont_eff);
			in_s3[0]   <= in_s2;
		end
		for (int k = 1; k < STEPS; k++) begin
			if (en[k + 2]) begin
				work_s3[k] <= div_step(work_s3[k - 1], cont_eff);
				in_s3[k]   <= in_s3[k - 1];
			end
		end
	end

	assign in_win = in_s3[STEPS-1];
	assign quot   = work_s3[STEPS-1][CFG_W-1:0];

endmodule
